// ----- src/jes_pkg.sv -----
// shared types, register codes and fixed-point helpers for the jacobi eigen solver
// depends on nothing; imported by every module of the block
package jes_pkg;

	typedef struct packed {
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
		logic               last;
	} jes_in_t;

	typedef struct packed {
		logic [2:0]         eig_index;
		logic [2:0]         component_index;
		logic signed [31:0] eigenvalue;
		logic signed [31:0] component;
		logic [15:0]        rotations_used;
		logic               final_res;
	} jes_out_t;

	localparam logic [1:0] CFG_SIZE_IN_USE       = 2'd0;
	localparam logic [1:0] CFG_MAX_ROTATIONS     = 2'd1;
	localparam logic [1:0] CFG_CONVERGENCE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_NEGZERO_BAND      = 2'd3;

	localparam logic [3:0]  RST_SIZE_IN_USE       = 4'd8;
	localparam logic [15:0] RST_MAX_ROTATIONS     = 16'd1000;
	localparam logic [31:0] RST_CONVERGENCE_LIMIT = 32'd429;
	localparam logic [15:0] RST_NEGZERO_BAND      = 16'd6;

	// round to nearest on magnitude, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
		input int unsigned sh);
		logic [63:0] m;
		m = v[63] ? (64'd0 - v) : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

endpackage

// ----- src/jes_div.sv -----
// unsigned 64 by 64 restoring divider, one quotient bit per cycle
// depends on jes_pkg
module jes_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	import jes_pkg::*;

	logic        run_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic        done_q;
	logic [64:0] rem_sh;

	assign rem_sh = {rem_q[63:0], quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- src/jes_isqrt.sv -----
// floor square root of a 64-bit word, two radicand bits per cycle
// depends on jes_pkg
module jes_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	import jes_pkg::*;

	logic        run_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic        done_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;

	assign rem_sh = {rem_q[33:0], x_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q <= {x_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- src/jacobi_eigen_solver_core.sv -----
// classical jacobi eigen solver: matrix and vector memories, sequencer, shared multiplier
// depends on jes_pkg, jes_div and jes_isqrt
//
// usage
//  - load channel: an item (row, col, value, last) is taken at a clock edge with start
//    high and busy low; each load writes one matrix element
//  - an item with last set stores its element and starts the solve; busy stays high
//    until the last result has been launched
//  - solve: a sweep that sets the whole vector memory to identity, then per rotation a
//    pivot scan over the upper triangle, two square roots and two divisions on the
//    shared units, an update of the matrix rows and then of the vector rows
//  - results: n*n items, eigenvalue index major, each shown on res for one cycle
//    with res_valid high; final_res marks the last one
//  - the receiver cannot stall, results are never held back
//  - config port: cfg_we writes cfg_data into register cfg_index at once; write it only
//    while the block is idle
//  - reset: registers go to their defaults, block idle; matrix memory holds no defined
//    contents until loaded, and a solve rotates it in place, so reload it each run
module jacobi_eigen_solver_core #(
	parameter int MAX_N     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  jes_pkg::jes_in_t  req,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output logic            res_valid,
	output jes_pkg::jes_out_t res
);
	import jes_pkg::*;

	localparam int NW    = $clog2(MAX_N + 1);
	localparam int AW    = $clog2(MAX_N * MAX_N);
	localparam int DEPTH = MAX_N * MAX_N;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	localparam logic [5:0] ST_LOAD   = 6'd0;
	localparam logic [5:0] ST_VINIT  = 6'd1;
	localparam logic [5:0] ST_SC_RD  = 6'd2;
	localparam logic [5:0] ST_SC_CAP = 6'd3;
	localparam logic [5:0] ST_SC_W   = 6'd4;
	localparam logic [5:0] ST_SC_ACC = 6'd5;
	localparam logic [5:0] ST_SC_END = 6'd6;
	localparam logic [5:0] ST_PD_RD  = 6'd7;
	localparam logic [5:0] ST_PD_RQ  = 6'd8;
	localparam logic [5:0] ST_PD_CQ  = 6'd9;
	localparam logic [5:0] ST_R1     = 6'd10;
	localparam logic [5:0] ST_R2     = 6'd11;
	localparam logic [5:0] ST_R3     = 6'd12;
	localparam logic [5:0] ST_R4     = 6'd13;
	localparam logic [5:0] ST_T1     = 6'd14;
	localparam logic [5:0] ST_T2     = 6'd15;
	localparam logic [5:0] ST_T3     = 6'd16;
	localparam logic [5:0] ST_T4     = 6'd17;
	localparam logic [5:0] ST_T5     = 6'd18;
	localparam logic [5:0] ST_T6     = 6'd19;
	localparam logic [5:0] ST_T7     = 6'd20;
	localparam logic [5:0] ST_T8     = 6'd21;
	localparam logic [5:0] ST_T9     = 6'd22;
	localparam logic [5:0] ST_T10    = 6'd23;
	localparam logic [5:0] ST_T11    = 6'd24;
	localparam logic [5:0] ST_OR_CHK = 6'd25;
	localparam logic [5:0] ST_OR_RQ  = 6'd26;
	localparam logic [5:0] ST_OR_CQ  = 6'd27;
	localparam logic [5:0] ST_OR_NP  = 6'd28;
	localparam logic [5:0] ST_OR_NQ  = 6'd29;
	localparam logic [5:0] ST_OR_W2  = 6'd30;
	localparam logic [5:0] ST_OR_W3  = 6'd31;
	localparam logic [5:0] ST_OR_W4  = 6'd32;
	localparam logic [5:0] ST_DG0    = 6'd33;
	localparam logic [5:0] ST_DG1    = 6'd34;
	localparam logic [5:0] ST_DG2    = 6'd35;
	localparam logic [5:0] ST_DG3    = 6'd36;
	localparam logic [5:0] ST_DG4    = 6'd37;
	localparam logic [5:0] ST_DG5    = 6'd38;
	localparam logic [5:0] ST_DG6    = 6'd39;
	localparam logic [5:0] ST_VR_CHK = 6'd40;
	localparam logic [5:0] ST_VR_RQ  = 6'd41;
	localparam logic [5:0] ST_VR_CQ  = 6'd42;
	localparam logic [5:0] ST_VR_NP  = 6'd43;
	localparam logic [5:0] ST_VR_NQ  = 6'd44;
	localparam logic [5:0] ST_VR_W2  = 6'd45;
	localparam logic [5:0] ST_L1     = 6'd46;
	localparam logic [5:0] ST_L2     = 6'd47;
	localparam logic [5:0] ST_L3     = 6'd48;
	localparam logic [5:0] ST_OUT_RD = 6'd49;
	localparam logic [5:0] ST_OUT_EM = 6'd50;

	// configuration registers
	logic [3:0]  size_q;
	logic [15:0] maxrot_q;
	logic [31:0] limit_q;
	logic [15:0] band_q;

	// sequencer state
	logic [5:0]  state_q, ret_q;
	logic [NW-1:0] n_q, i_q, j_q, r_q, p_q, q_q;
	logic        first_q;
	logic signed [33:0] best_q;
	logic signed [31:0] apq_q, app_q, aqq_q, u1_q, u2_q, np_q;
	logic [63:0] off_q, prev_q;
	logic [15:0] rot_q;
	logic [30:0] ad_q, ae_q;
	logic        neg_q;
	logic signed [32:0] t_q, c2_q, s2_q, sc2_q, k2_q, x2_q;
	logic signed [31:0] c_q, s_q;
	logic signed [32:0] mul_a_q, mul_b_q;
	logic signed [65:0] mul_p_q;
	logic signed [63:0] acc_q, lin_raw_q, x_q, y_q;
	logic signed [31:0] lin_sat;

	// shared unit handshakes
	logic        sq_go_q, dv_go_q, sq_done, dv_done;
	logic [63:0] sq_x_q, dv_num_q, dv_den_q, dv_quo;
	logic [31:0] sq_root;

	// memories
	logic signed [31:0] a_mem [DEPTH];
	logic signed [31:0] v_mem [DEPTH];
	logic signed [31:0] a_rdata_q, v_rdata_q;
	logic          a_we, v_we;
	logic [AW-1:0] a_waddr, a_raddr, v_waddr, v_raddr;
	logic signed [31:0] a_wdata, v_wdata;

	logic        accept;
	logic        load_ok;

	// pivot work
	logic signed [32:0] d_w, e_w;
	logic [32:0] ad_w, ae_w;
	logic [30:0] ad_s, ae_s;
	logic signed [33:0] vabs;
	logic [64:0] off_sum;
	logic [32:0] den_w;
	logic [32:0] tmag;
	logic signed [31:0] ev_w, comp_w;
	logic        flip_w, final_w;
	logic [NW-1:0] n_w;

	function automatic logic [AW-1:0] ma(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return AW'(int'(r) * MAX_N + int'(c));
	endfunction

	assign accept  = start && (state_q == ST_LOAD);
	assign busy    = (state_q != ST_LOAD);
	assign load_ok = (int'(req.row) < MAX_N) && (int'(req.col) < MAX_N);
	assign lin_sat = sat32(lin_raw_q);

	// size clamp at solve start
	always_comb begin
		if (size_q == 4'd0)
			n_w = NW'(1);
		else if (int'(size_q) > MAX_N)
			n_w = NW'(MAX_N);
		else
			n_w = NW'(size_q);
	end

	// rotation angle prep: d, e and their common right shift below 2^31
	always_comb begin
		d_w  = ext33(a_rdata_q) - ext33(app_q);
		e_w  = {apq_q, 1'b0};
		ad_w = d_w[32] ? 33'(-d_w) : 33'(d_w);
		ae_w = e_w[32] ? 33'(-e_w) : 33'(e_w);
		if (ad_w[32] || ae_w[32]) begin
			ad_s = ad_w[32:2];
			ae_s = ae_w[32:2];
		end else if (ad_w[31] || ae_w[31]) begin
			ad_s = ad_w[31:1];
			ae_s = ae_w[31:1];
		end else begin
			ad_s = ad_w[30:0];
			ae_s = ae_w[30:0];
		end
	end

	assign vabs    = a_rdata_q[31] ? -{{2{a_rdata_q[31]}}, a_rdata_q}
	                               : {{2{a_rdata_q[31]}}, a_rdata_q};
	assign off_sum = {1'b0, off_q} + {1'b0, mul_p_q[62:0], 1'b0};
	assign den_w   = {2'b00, ad_q} + {1'b0, sq_root};
	assign tmag    = dv_quo[32:0];

	// result formatting, near-zero negative eigenvalues snap to zero and their components are negated
	always_comb begin
		flip_w  = (n_q > NW'(1)) && a_rdata_q[31] &&
		          ($signed({a_rdata_q[31], a_rdata_q}) > -$signed({17'd0, band_q}));
		ev_w    = flip_w ? 32'sd0 : a_rdata_q;
		comp_w  = v_rdata_q;
		if (flip_w)
			comp_w = (v_rdata_q == 32'sh80000000) ? 32'sh7fffffff : -v_rdata_q;
		final_w = (i_q == n_q - NW'(1)) && (j_q == n_q - NW'(1));
	end

	// memory port selection
	always_comb begin
		a_we    = 1'b0;
		a_waddr = ma(r_q, p_q);
		a_wdata = np_q;
		v_we    = 1'b0;
		v_waddr = ma(r_q, p_q);
		v_wdata = np_q;
		a_raddr = ma(r_q, p_q);
		v_raddr = ma(r_q, p_q);
		case (state_q)
			ST_LOAD: begin
				a_we    = accept && load_ok;
				a_waddr = ma(NW'(req.row), NW'(req.col));
				a_wdata = req.value;
			end
			ST_VINIT: begin
				v_we    = 1'b1;
				v_waddr = ma(r_q, j_q);
				v_wdata = (r_q == j_q) ? ONE_Q : 32'sd0;
			end
			ST_SC_RD:  a_raddr = ma(i_q, j_q);
			ST_PD_RD:  a_raddr = ma(p_q, p_q);
			ST_PD_RQ:  a_raddr = ma(q_q, q_q);
			ST_OR_RQ:  a_raddr = ma(r_q, q_q);
			ST_OR_NQ:  a_we = 1'b1;
			ST_OR_W2: begin
				a_we    = 1'b1;
				a_waddr = ma(p_q, r_q);
			end
			ST_OR_W3: begin
				a_we    = 1'b1;
				a_waddr = ma(r_q, q_q);
				a_wdata = lin_sat;
			end
			ST_OR_W4: begin
				a_we    = 1'b1;
				a_waddr = ma(q_q, r_q);
				a_wdata = lin_sat;
			end
			ST_DG3: begin
				a_we    = 1'b1;
				a_waddr = ma(p_q, p_q);
				a_wdata = sat32(x_q - y_q);
			end
			ST_DG4: begin
				a_we    = 1'b1;
				a_waddr = ma(q_q, q_q);
				a_wdata = sat32(lin_raw_q + y_q);
			end
			ST_DG5: begin
				a_we    = 1'b1;
				a_waddr = ma(p_q, q_q);
				a_wdata = 32'sd0;
			end
			ST_DG6: begin
				a_we    = 1'b1;
				a_waddr = ma(q_q, p_q);
				a_wdata = 32'sd0;
			end
			ST_VR_RQ:  v_raddr = ma(r_q, q_q);
			ST_VR_NQ:  v_we = 1'b1;
			ST_VR_W2: begin
				v_we    = 1'b1;
				v_waddr = ma(r_q, q_q);
				v_wdata = lin_sat;
			end
			ST_OUT_RD: begin
				a_raddr = ma(i_q, i_q);
				v_raddr = ma(j_q, i_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[a_waddr] <= a_wdata;
		a_rdata_q <= a_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			v_mem[v_waddr] <= v_wdata;
		v_rdata_q <= v_mem[v_raddr];
	end

	// shared multiplier, one registered product per cycle
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a_q * mul_b_q;
	end

	jes_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go_q),
		.x      (sq_x_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	jes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dv_go_q),
		.num    (dv_num_q),
		.den    (dv_den_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= RST_SIZE_IN_USE;
			maxrot_q <= RST_MAX_ROTATIONS;
			limit_q  <= RST_CONVERGENCE_LIMIT;
			band_q   <= RST_NEGZERO_BAND;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_IN_USE:       size_q   <= cfg_data[3:0];
				CFG_MAX_ROTATIONS:     maxrot_q <= cfg_data[15:0];
				CFG_CONVERGENCE_LIMIT: limit_q  <= cfg_data;
				CFG_NEGZERO_BAND:      band_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ret_q       <= ST_LOAD;
			rot_q       <= '0;
			p_q         <= '0;
			q_q         <= '0;
			c_q         <= '0;
			s_q         <= '0;
			sq_go_q     <= 1'b0;
			dv_go_q     <= 1'b0;
			res_valid   <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			sq_go_q   <= 1'b0;
			dv_go_q   <= 1'b0;
			res_valid <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept && req.last) begin
						n_q     <= n_w;
						rot_q   <= '0;
						r_q     <= '0;
						j_q     <= '0;
						state_q <= ST_VINIT;
					end
				end
				// identity sweep over the whole vector memory
				ST_VINIT: begin
					if (int'(j_q) == MAX_N - 1) begin
						j_q <= '0;
						if (int'(r_q) == MAX_N - 1) begin
							i_q <= '0;
							if (n_q == NW'(1)) begin
								state_q <= ST_OUT_RD;
							end else begin
								first_q <= 1'b1;
								best_q  <= -34'sd1;
								off_q   <= '0;
								j_q     <= NW'(1);
								state_q <= ST_SC_RD;
							end
						end else begin
							r_q <= r_q + NW'(1);
						end
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				// pivot search and off-diagonal square sum, upper triangle
				ST_SC_RD:  state_q <= ST_SC_CAP;
				ST_SC_CAP: begin
					if (vabs > best_q) begin
						best_q <= vabs;
						p_q    <= i_q;
						q_q    <= j_q;
						apq_q  <= a_rdata_q;
					end
					mul_a_q <= ext33(a_rdata_q);
					mul_b_q <= ext33(a_rdata_q);
					state_q <= ST_SC_W;
				end
				ST_SC_W:   state_q <= ST_SC_ACC;
				ST_SC_ACC: begin
					off_q <= off_sum[64] ? '1 : off_sum[63:0];
					if (j_q + NW'(1) < n_q) begin
						j_q     <= j_q + NW'(1);
						state_q <= ST_SC_RD;
					end else if (i_q + NW'(2) < n_q) begin
						i_q     <= i_q + NW'(1);
						j_q     <= i_q + NW'(2);
						state_q <= ST_SC_RD;
					end else begin
						state_q <= ST_SC_END;
					end
				end
				ST_SC_END: begin
					i_q    <= '0;
					j_q    <= '0;
					prev_q <= off_q;
					if (!first_q && (off_q >= prev_q ||
					    prev_q - off_q <= {32'd0, limit_q}))
						state_q <= ST_OUT_RD;
					else if (rot_q >= maxrot_q)
						state_q <= ST_OUT_RD;
					else if (apq_q == 32'sd0)
						state_q <= ST_OUT_RD;
					else
						state_q <= ST_PD_RD;
				end
				// diagonal pair fetch and the rotation angle
				ST_PD_RD:  state_q <= ST_PD_RQ;
				ST_PD_RQ: begin
					app_q   <= a_rdata_q;
					state_q <= ST_PD_CQ;
				end
				ST_PD_CQ: begin
					aqq_q   <= a_rdata_q;
					ad_q    <= ad_s;
					ae_q    <= ae_s;
					neg_q   <= (d_w != 33'sd0) && (d_w[32] != e_w[32]);
					mul_a_q <= $signed({2'b00, ad_s});
					mul_b_q <= $signed({2'b00, ad_s});
					state_q <= ST_R1;
				end
				ST_R1: begin
					mul_a_q <= $signed({2'b00, ae_q});
					mul_b_q <= $signed({2'b00, ae_q});
					state_q <= ST_R2;
				end
				ST_R2: begin
					acc_q   <= mul_p_q[63:0];
					state_q <= ST_R3;
				end
				ST_R3: begin
					sq_x_q  <= acc_q + mul_p_q[63:0];
					sq_go_q <= 1'b1;
					state_q <= ST_R4;
				end
				ST_R4: begin
					if (sq_done) begin
						dv_num_q <= (64'(ae_q) << FRAC_BITS) + 64'(den_w >> 1);
						dv_den_q <= 64'(den_w);
						dv_go_q  <= 1'b1;
						state_q  <= ST_T1;
					end
				end
				ST_T1: begin
					if (dv_done) begin
						t_q     <= neg_q ? -$signed(tmag) : $signed(tmag);
						mul_a_q <= $signed(tmag);
						mul_b_q <= $signed(tmag);
						state_q <= ST_T2;
					end
				end
				ST_T2: state_q <= ST_T3;
				ST_T3: begin
					sq_x_q  <= mul_p_q[63:0] + (64'd1 << (2 * FRAC_BITS));
					sq_go_q <= 1'b1;
					state_q <= ST_T4;
				end
				ST_T4: begin
					if (sq_done) begin
						dv_num_q <= (64'd1 << (2 * FRAC_BITS)) + 64'(sq_root >> 1);
						dv_den_q <= 64'(sq_root);
						dv_go_q  <= 1'b1;
						state_q  <= ST_T5;
					end
				end
				ST_T5: begin
					if (dv_done) begin
						c_q     <= dv_quo[31:0];
						mul_a_q <= t_q;
						mul_b_q <= ext33(dv_quo[31:0]);
						state_q <= ST_T6;
					end
				end
				ST_T6: state_q <= ST_T7;
				ST_T7: begin
					s_q     <= 32'(rnd_shift(mul_p_q[63:0], FRAC_BITS));
					mul_a_q <= ext33(c_q);
					mul_b_q <= ext33(c_q);
					state_q <= ST_T8;
				end
				ST_T8: begin
					mul_a_q <= ext33(s_q);
					mul_b_q <= ext33(s_q);
					state_q <= ST_T9;
				end
				ST_T9: begin
					c2_q    <= 33'(rnd_shift(mul_p_q[63:0], FRAC_BITS));
					mul_a_q <= ext33(s_q);
					mul_b_q <= ext33(c_q);
					state_q <= ST_T10;
				end
				ST_T10: begin
					s2_q    <= 33'(rnd_shift(mul_p_q[63:0], FRAC_BITS));
					state_q <= ST_T11;
				end
				ST_T11: begin
					sc2_q   <= 33'(rnd_shift(mul_p_q[63:0], FRAC_BITS)) <<< 1;
					r_q     <= '0;
					state_q <= ST_OR_CHK;
				end
				// rows other than p and q: columns p and q and their mirrors
				ST_OR_CHK: begin
					if (r_q == n_q)
						state_q <= ST_DG0;
					else if (r_q == p_q || r_q == q_q)
						r_q <= r_q + NW'(1);
					else
						state_q <= ST_OR_RQ;
				end
				ST_OR_RQ: begin
					u1_q    <= a_rdata_q;
					state_q <= ST_OR_CQ;
				end
				ST_OR_CQ: begin
					u2_q    <= a_rdata_q;
					mul_a_q <= ext33(c_q);
					mul_b_q <= ext33(u1_q);
					k2_q    <= -ext33(s_q);
					x2_q    <= ext33(a_rdata_q);
					ret_q   <= ST_OR_NP;
					state_q <= ST_L1;
				end
				ST_OR_NP: begin
					np_q    <= lin_sat;
					mul_a_q <= ext33(c_q);
					mul_b_q <= ext33(u2_q);
					k2_q    <= ext33(s_q);
					x2_q    <= ext33(u1_q);
					ret_q   <= ST_OR_NQ;
					state_q <= ST_L1;
				end
				ST_OR_NQ: state_q <= ST_OR_W2;
				ST_OR_W2: state_q <= ST_OR_W3;
				ST_OR_W3: state_q <= ST_OR_W4;
				ST_OR_W4: begin
					r_q     <= r_q + NW'(1);
					state_q <= ST_OR_CHK;
				end
				// new diagonal pair, pivot pair cleared
				ST_DG0: begin
					mul_a_q <= c2_q;
					mul_b_q <= ext33(app_q);
					k2_q    <= s2_q;
					x2_q    <= ext33(aqq_q);
					ret_q   <= ST_DG1;
					state_q <= ST_L1;
				end
				ST_DG1: begin
					x_q     <= lin_raw_q;
					mul_a_q <= sc2_q;
					mul_b_q <= ext33(apq_q);
					k2_q    <= '0;
					x2_q    <= '0;
					ret_q   <= ST_DG2;
					state_q <= ST_L1;
				end
				ST_DG2: begin
					y_q     <= lin_raw_q;
					mul_a_q <= s2_q;
					mul_b_q <= ext33(app_q);
					k2_q    <= c2_q;
					x2_q    <= ext33(aqq_q);
					ret_q   <= ST_DG3;
					state_q <= ST_L1;
				end
				ST_DG3: state_q <= ST_DG4;
				ST_DG4: state_q <= ST_DG5;
				ST_DG5: state_q <= ST_DG6;
				ST_DG6: begin
					r_q     <= '0;
					state_q <= ST_VR_CHK;
				end
				// vector columns p and q
				ST_VR_CHK: begin
					if (r_q == n_q) begin
						rot_q   <= rot_q + 16'd1;
						first_q <= 1'b0;
						best_q  <= -34'sd1;
						off_q   <= '0;
						i_q     <= '0;
						j_q     <= NW'(1);
						state_q <= ST_SC_RD;
					end else begin
						state_q <= ST_VR_RQ;
					end
				end
				ST_VR_RQ: begin
					u1_q    <= v_rdata_q;
					state_q <= ST_VR_CQ;
				end
				ST_VR_CQ: begin
					u2_q    <= v_rdata_q;
					mul_a_q <= ext33(c_q);
					mul_b_q <= ext33(u1_q);
					k2_q    <= -ext33(s_q);
					x2_q    <= ext33(v_rdata_q);
					ret_q   <= ST_VR_NP;
					state_q <= ST_L1;
				end
				ST_VR_NP: begin
					np_q    <= lin_sat;
					mul_a_q <= ext33(c_q);
					mul_b_q <= ext33(u2_q);
					k2_q    <= ext33(s_q);
					x2_q    <= ext33(u1_q);
					ret_q   <= ST_VR_NQ;
					state_q <= ST_L1;
				end
				ST_VR_NQ: state_q <= ST_VR_W2;
				ST_VR_W2: begin
					r_q     <= r_q + NW'(1);
					state_q <= ST_VR_CHK;
				end
				// two-product sum with rounding, first product already issued
				ST_L1: begin
					mul_a_q <= k2_q;
					mul_b_q <= x2_q;
					state_q <= ST_L2;
				end
				ST_L2: begin
					acc_q   <= mul_p_q[63:0];
					state_q <= ST_L3;
				end
				ST_L3: begin
					lin_raw_q <= rnd_shift(acc_q + mul_p_q[63:0], FRAC_BITS);
					state_q   <= ret_q;
				end
				// result stream, each item read in ST_OUT_RD and emitted in ST_OUT_EM
				ST_OUT_RD: state_q <= ST_OUT_EM;
				ST_OUT_EM: begin
					res_valid           <= 1'b1;
					res.eig_index       <= 3'(i_q);
					res.component_index <= 3'(j_q);
					res.eigenvalue      <= ev_w;
					res.component       <= comp_w;
					res.rotations_used  <= rot_q;
					res.final_res       <= final_w;
					if (final_w) begin
						state_q <= ST_LOAD;
					end else if (j_q + NW'(1) < n_q) begin
						j_q     <= j_q + NW'(1);
						state_q <= ST_OUT_RD;
					end else begin
						j_q     <= '0;
						i_q     <= i_q + NW'(1);
						state_q <= ST_OUT_RD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- src/jes_checker.sv -----
// port-level checks of the jacobi eigen solver and their bind to the top level
// depends on jes_pkg and jacobi_eigen_solver_core
module jes_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input jes_pkg::jes_in_t  req,
	input logic              res_valid,
	input jes_pkg::jes_out_t res
);
	import jes_pkg::*;

	// a plain load never starts a solve
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !req.last |=> !busy)
		else $error("plain load made the block busy");

	// the closing load starts the solve
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.last |=> busy)
		else $error("closing load did not start the solve");

	// more results follow while the run is open
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.final_res |=> busy)
		else $error("run ended before its final result");

	// nothing trails the final result
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.final_res |=> !res_valid)
		else $error("result after the final one");
endmodule

bind jacobi_eigen_solver_core jes_checker u_jes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req       (req),
	.res_valid (res_valid),
	.res       (res)
);
